>>> hw/rtl/ceu_pkg.sv
// ----------------------------------------------------------------------------
// ceu_pkg: shared types and constants for the complex envelope upsampler
// register codes, mode codes, reset values and the sequencer state type
// ----------------------------------------------------------------------------
`default_nettype none

package ceu_pkg;

	localparam int FACTOR_W = 7;
	localparam int MODE_W   = 2;
	localparam int PHASE_W  = 6;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_FACTOR = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_PHASE  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd2;

	localparam logic [FACTOR_W-1:0] FACTOR_RST = 7'd5;
	localparam logic [MODE_W-1:0]   MODE_RST   = MODE_HOLD;
	localparam logic [PHASE_W-1:0]  PHASE_RST  = 6'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_I_GO,
		ST_DIV_I_WAIT,
		ST_DIV_Q_GO,
		ST_DIV_Q_WAIT,
		ST_EMIT
	} ceu_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/ceu_div.sv
// ----------------------------------------------------------------------------
// ceu_div: bit-serial floor divider
// signed dividend over unsigned divisor, one quotient bit per cycle,
// floor quotient and non-negative remainder
// ----------------------------------------------------------------------------
`default_nettype none

module ceu_div #(
	parameter int DW = 17,
	parameter int VW = 7
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire signed [DW-1:0]  dividend,
	input  wire        [VW-1:0]  divisor,
	output logic                 done,
	output logic signed [DW:0]   quot,
	output logic       [VW-1:0]  rem
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    mag_q;
	logic [VW-1:0]    rem_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VW:0]      trial;
	logic             fits;
	logic [DW:0]      q0;

	assign trial = {rem_q, mag_q[DW-1]};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift into the magnitude register as it empties
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			mag_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
			mag_q <= {mag_q[DW-2:0], fits};
		end
	end

	// floor correction for negative dividends
	assign q0   = {1'b0, mag_q};
	assign done = done_q;

	always_comb begin
		if (!neg_q) begin
			quot = $signed(q0);
			rem  = rem_q;
		end else if (rem_q != '0) begin
			quot = $signed(~q0);
			rem  = divisor - rem_q;
		end else begin
			quot = $signed(-q0);
			rem  = '0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/complex_envelope_upsampler.sv
// ----------------------------------------------------------------------------
// complex_envelope_upsampler: I/Q upsampler with zero-insert, hold and linear
// each input request yields a burst of factor output requests, last flagged
// ----------------------------------------------------------------------------
// zero-insert and hold: acceptance moves the sequencer to its emit state and the
//   output register takes the first output, then one output per cycle while out_ready is high
// linear: two passes of the shared bit-serial divider, one for I and one for Q,
//   then the output burst and a return to idle;
//   in_ready is low while a burst is in work
// reset: factor 5, mode hold, phase 0, stored previous sample zero
`default_nettype none

module complex_envelope_upsampler #(
	parameter int MAX_FACTOR  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,

	// configuration port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [ceu_pkg::ADDR_W-1:0]          paddr,
	input  wire  [ceu_pkg::DATA_W-1:0]          pwdata,
	output logic [ceu_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,

	// input channel
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire signed [SAMPLE_BITS-1:0]        in_i,
	input  wire signed [SAMPLE_BITS-1:0]        in_q,

	// output channel
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]       out_i,
	output logic signed [SAMPLE_BITS-1:0]       out_q,
	output logic                                last
);

	// effective factor width, difference width, step width and compare width
	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int DW = SAMPLE_BITS + 1;
	localparam int QW = SAMPLE_BITS + 2;
	localparam int CW = (FW > ceu_pkg::PHASE_W) ? FW : ceu_pkg::PHASE_W;

	// configuration registers
	logic [ceu_pkg::FACTOR_W-1:0] factor_q;
	logic [ceu_pkg::MODE_W-1:0]   mode_q;
	logic [ceu_pkg::PHASE_W-1:0]  phase_q;
	logic                         cfg_wr;

	// sequencer
	ceu_pkg::ceu_state_t state_q, state_d;
	logic                emit;
	logic                div_start;
	logic                div_sel;
	logic                burst_end;

	// per-request snapshot
	logic signed [SAMPLE_BITS-1:0] cur_i_q, cur_q_q;
	logic signed [SAMPLE_BITS-1:0] prev_i_q, prev_q_q;
	logic [FW-1:0]                 feff_q;
	logic [FW-1:0]                 ph_q;
	logic [ceu_pkg::MODE_W-1:0]    md_q;
	logic [FW-1:0]                 j_q;

	// effective factor and phase from the registers
	logic [FW-1:0] f_eff;
	logic [FW-1:0] ph_eff;

	// linear ramp: quotient and remainder steps, running sums
	logic signed [QW-1:0] step_i_q, step_q_q;
	logic [FW-1:0]        rstep_i_q, rstep_q_q;
	logic signed [QW-1:0] acc_i_q, acc_q_q;
	logic [FW-1:0]        racc_i_q, racc_q_q;
	logic [FW:0]          rsum_i, rsum_q;
	logic                 wrap_i, wrap_q;

	// divider hookup
	logic signed [DW-1:0] diff_i, diff_q, div_num;
	logic                 div_done;
	logic signed [QW-1:0] div_quot;
	logic [FW-1:0]        div_rem;

	// next output sample
	logic signed [SAMPLE_BITS-1:0] smp_i, smp_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= ceu_pkg::FACTOR_RST;
			mode_q   <= ceu_pkg::MODE_RST;
			phase_q  <= ceu_pkg::PHASE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				ceu_pkg::REG_FACTOR: factor_q <= pwdata[ceu_pkg::FACTOR_W-1:0];
				ceu_pkg::REG_MODE:   mode_q   <= pwdata[ceu_pkg::MODE_W-1:0];
				ceu_pkg::REG_PHASE:  phase_q  <= pwdata[ceu_pkg::PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ceu_pkg::REG_FACTOR: prdata = ceu_pkg::DATA_W'(factor_q);
			ceu_pkg::REG_MODE:   prdata = ceu_pkg::DATA_W'(mode_q);
			ceu_pkg::REG_PHASE:  prdata = ceu_pkg::DATA_W'(phase_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- factor and phase saturation ----------------
	always_comb begin
		if (factor_q == '0)
			f_eff = FW'(1);
		else if (factor_q > ceu_pkg::FACTOR_W'(MAX_FACTOR))
			f_eff = FW'(MAX_FACTOR);
		else
			f_eff = FW'(factor_q);

		// phase clamps to the last slot of the burst
		if (CW'(phase_q) > CW'(f_eff - 1'b1))
			ph_eff = f_eff - 1'b1;
		else
			ph_eff = FW'(phase_q);
	end

	// ---------------- sequencer ----------------
	assign burst_end = (j_q == feff_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ceu_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		div_sel   = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ceu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode_q == ceu_pkg::MODE_LINEAR)
						state_d = ceu_pkg::ST_DIV_I_GO;
					else
						state_d = ceu_pkg::ST_EMIT;
				end
			end
			ceu_pkg::ST_DIV_I_GO: begin
				div_start = 1'b1;
				state_d   = ceu_pkg::ST_DIV_I_WAIT;
			end
			ceu_pkg::ST_DIV_I_WAIT: begin
				if (div_done)
					state_d = ceu_pkg::ST_DIV_Q_GO;
			end
			ceu_pkg::ST_DIV_Q_GO: begin
				div_start = 1'b1;
				div_sel   = 1'b1;
				state_d   = ceu_pkg::ST_DIV_Q_WAIT;
			end
			ceu_pkg::ST_DIV_Q_WAIT: begin
				if (div_done)
					state_d = ceu_pkg::ST_EMIT;
			end
			ceu_pkg::ST_EMIT: begin
				// output register takes a sample when it is empty or draining
				emit = !out_valid || out_ready;
				if (emit && burst_end)
					state_d = ceu_pkg::ST_IDLE;
			end
			default: state_d = ceu_pkg::ST_IDLE;
		endcase
	end

	// ---------------- request snapshot and stored sample ----------------
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_i_q <= in_i;
			cur_q_q <= in_q;
			feff_q  <= f_eff;
			ph_q    <= ph_eff;
			md_q    <= mode_q;
		end
	end

	// previous sample only moves at the end of a linear burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q <= '0;
			prev_q_q <= '0;
		end else if (emit && burst_end && md_q == ceu_pkg::MODE_LINEAR) begin
			prev_i_q <= cur_i_q;
			prev_q_q <= cur_q_q;
		end
	end

	// ---------------- shared divider: curr - prev over factor ----------------
	assign diff_i  = DW'(cur_i_q) - DW'(prev_i_q);
	assign diff_q  = DW'(cur_q_q) - DW'(prev_q_q);
	assign div_num = div_sel ? diff_q : diff_i;

	ceu_div #(
		.DW (DW),
		.VW (FW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (feff_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// ---------------- ramp accumulators ----------------
	// j*d/f tracked as quotient plus remainder; remainder wraps at factor
	assign rsum_i = {1'b0, racc_i_q} + {1'b0, rstep_i_q};
	assign rsum_q = {1'b0, racc_q_q} + {1'b0, rstep_q_q};
	assign wrap_i = (rsum_i >= {1'b0, feff_q});
	assign wrap_q = (rsum_q >= {1'b0, feff_q});

	always_ff @(posedge clk) begin
		if (state_q == ceu_pkg::ST_DIV_I_WAIT && div_done) begin
			step_i_q  <= div_quot;
			rstep_i_q <= div_rem;
		end
		if (state_q == ceu_pkg::ST_DIV_Q_WAIT && div_done) begin
			step_q_q  <= div_quot;
			rstep_q_q <= div_rem;
		end
		if (in_valid && in_ready) begin
			j_q      <= '0;
			acc_i_q  <= '0;
			acc_q_q  <= '0;
			racc_i_q <= '0;
			racc_q_q <= '0;
		end else if (emit) begin
			j_q      <= j_q + 1'b1;
			acc_i_q  <= acc_i_q + step_i_q + QW'(wrap_i);
			acc_q_q  <= acc_q_q + step_q_q + QW'(wrap_q);
			racc_i_q <= wrap_i ? FW'(rsum_i - {1'b0, feff_q}) : FW'(rsum_i);
			racc_q_q <= wrap_q ? FW'(rsum_q - {1'b0, feff_q}) : FW'(rsum_q);
		end
	end

	// ---------------- sample select ----------------
	always_comb begin
		case (md_q)
			ceu_pkg::MODE_ZERO: begin
				smp_i = (j_q == ph_q) ? cur_i_q : '0;
				smp_q = (j_q == ph_q) ? cur_q_q : '0;
			end
			ceu_pkg::MODE_LINEAR: begin
				// ramp stays between prev and curr, so truncation is exact
				smp_i = SAMPLE_BITS'(QW'(prev_i_q) + acc_i_q);
				smp_q = SAMPLE_BITS'(QW'(prev_q_q) + acc_q_q);
			end
			default: begin
				smp_i = cur_i_q;
				smp_q = cur_q_q;
			end
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_i <= smp_i;
			out_q <= smp_q;
			last  <= burst_end;
		end
	end

endmodule

`default_nettype wire

>>> tb/ceu_burst_checker.sv
// ----------------------------------------------------------------------------
// ceu_burst_checker: burst predictor and scoreboard for the upsampler
// mirrors register writes, expands each accepted input request into its
// burst of expected output requests and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ceu_burst_checker #(
	parameter int MAX_FACTOR  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic [ceu_pkg::ADDR_W-1:0]        paddr,
	input  logic [ceu_pkg::DATA_W-1:0]        pwdata,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     in_i,
	input  logic signed [SAMPLE_BITS-1:0]     in_q,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [SAMPLE_BITS-1:0]     out_i,
	input  logic signed [SAMPLE_BITS-1:0]     out_q,
	input  logic                              last,
	output int                                mismatches,
	output int                                pending
);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] i;
		logic signed [SAMPLE_BITS-1:0] q;
		logic                          last;
	} env_sample_t;

	env_sample_t burst_q[$];

	logic [ceu_pkg::FACTOR_W-1:0]  cfg_factor;
	logic [ceu_pkg::MODE_W-1:0]    cfg_mode;
	logic [ceu_pkg::PHASE_W-1:0]   cfg_phase;
	logic signed [SAMPLE_BITS-1:0] hist_i;
	logic signed [SAMPLE_BITS-1:0] hist_q;

	// quotient rounded toward minus infinity
	function automatic longint floor_quot(longint num, longint den);
		longint quo;
		quo = num / den;
		if ((num % den) != 0 && num < 0)
			quo = quo - 1;
		return quo;
	endfunction

	function automatic void predict_burst(logic signed [SAMPLE_BITS-1:0] ci,
			logic signed [SAMPLE_BITS-1:0] cq);
		int          span;
		int          pos;
		longint      di;
		longint      dq;
		env_sample_t s;
		span = (cfg_factor == 0) ? 1 : ((cfg_factor > MAX_FACTOR) ? MAX_FACTOR : cfg_factor);
		pos  = (int'(cfg_phase) > span - 1) ? span - 1 : int'(cfg_phase);
		di   = longint'(ci) - longint'(hist_i);
		dq   = longint'(cq) - longint'(hist_q);
		for (int j = 0; j < span; j++) begin
			case (cfg_mode)
				ceu_pkg::MODE_ZERO: begin
					s.i = (j == pos) ? ci : '0;
					s.q = (j == pos) ? cq : '0;
				end
				ceu_pkg::MODE_LINEAR: begin
					s.i = SAMPLE_BITS'(longint'(hist_i) + floor_quot(longint'(j) * di, span));
					s.q = SAMPLE_BITS'(longint'(hist_q) + floor_quot(longint'(j) * dq, span));
				end
				default: begin
					s.i = ci;
					s.q = cq;
				end
			endcase
			s.last = (j == span - 1);
			burst_q.insert(burst_q.size(), s);
		end
		if (cfg_mode == ceu_pkg::MODE_LINEAR) begin
			hist_i = ci;
			hist_q = cq;
		end
	endfunction

	function automatic void report_mismatch(string what, env_sample_t exp_s);
		if (mismatches < 10)
			$display("%0t: %s: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
				$realtime, what, exp_s.i, exp_s.q, exp_s.last, out_i, out_q, last);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		env_sample_t exp_s;
		if (!arst_n) begin
			cfg_factor = ceu_pkg::FACTOR_RST;
			cfg_mode   = ceu_pkg::MODE_RST;
			cfg_phase  = ceu_pkg::PHASE_RST;
			hist_i     = '0;
			hist_q     = '0;
			mismatches = 0;
			burst_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					ceu_pkg::REG_FACTOR: cfg_factor = pwdata[ceu_pkg::FACTOR_W-1:0];
					ceu_pkg::REG_MODE:   cfg_mode   = pwdata[ceu_pkg::MODE_W-1:0];
					ceu_pkg::REG_PHASE:  cfg_phase  = pwdata[ceu_pkg::PHASE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_burst(in_i, in_q);
			if (out_valid && out_ready) begin
				if (burst_q.size() == 0) begin
					exp_s = '0;
					report_mismatch("output with nothing expected", exp_s);
				end else begin
					exp_s = burst_q.pop_front();
					if (exp_s.i !== out_i || exp_s.q !== out_q || exp_s.last !== last)
						report_mismatch("output mismatch", exp_s);
				end
			end
		end
		pending = burst_q.size();
	end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for complex_envelope_upsampler
// directed corner cases, then random register settings and samples under
// several sender/receiver idle patterns; the burst checker does the scoring
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int SAMPLE_BITS = 16;
	localparam int ROUNDS      = 16;
	localparam int ROUND_ITEMS = 30;

	// register slot with nothing behind it, writes must be ignored
	localparam logic [1:0] REG_SPARE = 2'd3;
	// the unused mode code behaves like hold
	localparam logic [ceu_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam logic signed [SAMPLE_BITS-1:0] SMAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = 16'sh8000;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [ceu_pkg::ADDR_W-1:0]    paddr     = '0;
	logic [ceu_pkg::DATA_W-1:0]    pwdata    = '0;
	logic                          in_valid  = 1'b0;
	logic signed [SAMPLE_BITS-1:0] in_i      = '0;
	logic signed [SAMPLE_BITS-1:0] in_q      = '0;
	logic                          out_ready = 1'b0;

	wire [ceu_pkg::DATA_W-1:0]     prdata;
	wire                           pready;
	wire                           in_ready;
	wire                           out_valid;
	wire signed [SAMPLE_BITS-1:0]  out_i;
	wire signed [SAMPLE_BITS-1:0]  out_q;
	wire                           last;

	// idle percentages of the current traffic phase
	int in_idle_pct   = 0;
	int out_stall_pct = 0;

	int mismatches;
	int pending;

	complex_envelope_upsampler #(
		.MAX_FACTOR (64),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_i     (in_i),
		.in_q     (in_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_i    (out_i),
		.out_q    (out_q),
		.last     (last)
	);

	ceu_burst_checker #(
		.MAX_FACTOR (64),
		.SAMPLE_BITS(SAMPLE_BITS)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_i      (in_i),
		.in_q      (in_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_i     (out_i),
		.out_q     (out_q),
		.last      (last),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure, one coin per cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(1, 100) > out_stall_pct);
	end

	// hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// one register write: setup phase, access phase, then the bus returns to idle
	task automatic cfg_write(logic [1:0] idx, logic [ceu_pkg::DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// sometimes fill the bits above the field with junk, the block must mask them
	function automatic logic [ceu_pkg::DATA_W-1:0] pad_upper(logic [ceu_pkg::DATA_W-1:0] v,
			int w);
		if ($urandom_range(0, 3) == 0)
			return v | (ceu_pkg::DATA_W'($urandom) << w);
		return v;
	endfunction

	// present one sample and hold it until the request is taken;
	// valid is only dropped when the sender decides to idle
	task automatic push_sample(logic signed [SAMPLE_BITS-1:0] si,
			logic signed [SAMPLE_BITS-1:0] sq);
		in_valid <= 1'b1;
		in_i     <= si;
		in_q     <= sq;
		do
			@(posedge clk);
		while (!in_ready);
		if (in_idle_pct > 0 && $urandom_range(1, 100) <= in_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(1, 100) <= in_idle_pct);
		end
	endtask

	// stop sending and wait until every predicted output has come out;
	// first edge lets the checker see the last accepted request
	task automatic drain_bursts();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reconfig(logic [ceu_pkg::FACTOR_W-1:0] f, logic [ceu_pkg::MODE_W-1:0] m,
			logic [ceu_pkg::PHASE_W-1:0] p);
		drain_bursts();
		cfg_write(ceu_pkg::REG_FACTOR, pad_upper(ceu_pkg::DATA_W'(f), ceu_pkg::FACTOR_W));
		cfg_write(ceu_pkg::REG_MODE, pad_upper(ceu_pkg::DATA_W'(m), ceu_pkg::MODE_W));
		cfg_write(ceu_pkg::REG_PHASE, pad_upper(ceu_pkg::DATA_W'(p), ceu_pkg::PHASE_W));
	endtask

	task automatic set_traffic(int sel);
		case (sel)
			0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
			1: begin in_idle_pct = 46; out_stall_pct = 0;  end
			2: begin in_idle_pct = 0;  out_stall_pct = 46; end
			default: begin in_idle_pct = 20; out_stall_pct = 20; end
		endcase
	endtask

	// mostly full-range values, with rail values and tiny values mixed in
	function automatic logic signed [SAMPLE_BITS-1:0] rand_component();
		case ($urandom_range(0, 9))
			0: return SMAX;
			1: return SMIN;
			2: return SAMPLE_BITS'($urandom_range(0, 16)) - 16'sd8;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		logic [ceu_pkg::FACTOR_W-1:0] f;
		logic [ceu_pkg::MODE_W-1:0]   m;
		logic [ceu_pkg::PHASE_W-1:0]  p;

		// reset held low, then released on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---------------- directed part, no idling ----------------
		set_traffic(0);

		// reset settings: factor 5, hold; rail values both ways round
		push_sample(SMAX, SMIN);
		push_sample(SMIN, SMAX);
		push_sample(16'sd0, 16'sd0);

		// unused mode code acts as hold
		drain_bursts();
		cfg_write(ceu_pkg::REG_MODE, ceu_pkg::DATA_W'(MODE_SPARE));
		push_sample(16'sd1234, -16'sd1);

		// factor zero gives a single output
		reconfig(7'd0, ceu_pkg::MODE_HOLD, 6'd0);
		push_sample(-16'sd1, -16'sd1);

		// factor above the maximum saturates, phase at its top
		reconfig(7'd127, ceu_pkg::MODE_ZERO, 6'd63);
		push_sample(16'sd100, -16'sd100);

		// zero insert in the middle of the burst, then phase past the burst end
		reconfig(7'd4, ceu_pkg::MODE_ZERO, 6'd2);
		push_sample(SMIN, SMAX);
		drain_bursts();
		cfg_write(ceu_pkg::REG_PHASE, ceu_pkg::DATA_W'(6'd63));
		push_sample(16'sd7, 16'sd8);

		// zero insert with a one-sample burst
		reconfig(7'd1, ceu_pkg::MODE_ZERO, 6'd0);
		push_sample(16'sd5, 16'sd6);

		// first linear request ramps up from the zero history; full-swing
		// ramps exercise floor rounding of negative steps
		reconfig(7'd7, ceu_pkg::MODE_LINEAR, 6'd0);
		push_sample(SMAX, SMIN);
		push_sample(SMIN, SMAX);
		push_sample(-16'sd3, 16'sd3);
		push_sample(-16'sd3, 16'sd3);

		// longest linear burst
		reconfig(7'd64, ceu_pkg::MODE_LINEAR, 6'd0);
		push_sample(SMAX, SMIN);
		push_sample(SMIN, SMAX);

		// linear with factor one outputs the stored sample only
		reconfig(7'd1, ceu_pkg::MODE_LINEAR, 6'd0);
		push_sample(16'sd11, -16'sd11);

		// write to the unused slot must change nothing
		drain_bursts();
		cfg_write(REG_SPARE, '1);
		cfg_write(ceu_pkg::REG_FACTOR, ceu_pkg::DATA_W'(7'd3));
		push_sample(16'sd0, 16'sd0);

		// linear with factor zero
		drain_bursts();
		cfg_write(ceu_pkg::REG_FACTOR, ceu_pkg::DATA_W'(7'd0));
		push_sample(-16'sd20, 16'sd20);

		// ---------------- random part ----------------
		for (int r = 0; r < ROUNDS; r++) begin
			// factor: mostly short bursts, some long, a few at the extremes
			case ($urandom_range(0, 19))
				0: begin
					case ($urandom_range(0, 3))
						0: f = 7'd0;
						1: f = 7'd1;
						2: f = 7'd64;
						default: f = ceu_pkg::FACTOR_W'($urandom_range(65, 127));
					endcase
				end
				1, 2: f = ceu_pkg::FACTOR_W'($urandom_range(9, 64));
				default: f = ceu_pkg::FACTOR_W'($urandom_range(1, 8));
			endcase
			// linear is the deepest path, so it gets half the rounds
			case ($urandom_range(0, 7))
				0, 1: m = ceu_pkg::MODE_ZERO;
				2:    m = ceu_pkg::MODE_HOLD;
				3:    m = MODE_SPARE;
				default: m = ceu_pkg::MODE_LINEAR;
			endcase
			if ($urandom_range(0, 1) == 1)
				p = ceu_pkg::PHASE_W'($urandom_range(0, 63));
			else
				p = ceu_pkg::PHASE_W'($urandom_range(0, (f > 63) ? 63 : f));

			reconfig(f, m, p);
			if ($urandom_range(0, 3) == 0)
				cfg_write(REG_SPARE, ceu_pkg::DATA_W'($urandom));
			set_traffic(r % 4);

			for (int k = 0; k < ROUND_ITEMS; k++) begin
				push_sample(rand_component(), rand_component());
				// sender holds off until the block has emptied completely
				if (r % 5 == 2 && k == ROUND_ITEMS / 2)
					drain_bursts();
			end
		end

		// wait out the tail, long enough for a stray extra output to show
		drain_bursts();
		repeat (110) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
